// File: hw/rtl/lfpf_pkg.sv
package lfpf_pkg;

    // Default number of channels whose history is kept.
    localparam int CHANNELS_DEF = 5;

    // Field widths.
    localparam int CH_W    = 3;
    localparam int SMP_W   = 14;
    localparam int COEFF_W = 24;
    localparam int ADC_W   = 12;
    localparam int MULT_W  = 8;
    localparam int SHF_W   = 4;
    localparam int SHAMT_W = 5;
    localparam int LPROD_W = ADC_W + MULT_W;
    localparam int X_W     = 18;
    localparam int FILT_W  = 18;
    localparam int AMP_W   = 10;

    // Filter arithmetic.
    localparam int NTAPS   = 5;
    localparam int WGT_W   = 7;
    localparam int TPROD_W = X_W + 1 + WGT_W;
    localparam int FRAC_W  = 6;
    localparam int TERM_W  = TPROD_W - FRAC_W;
    localparam int ACC_W   = TERM_W + 4;
    localparam int SAT_W   = 12;

    localparam logic signed [WGT_W-1:0] TAP_WGT [NTAPS] = '{
        7'sd24, 7'sd31, 7'sd16, -7'sd35, -7'sd36
    };

    localparam logic [SHAMT_W-1:0] SHIFT_BIAS = 5'd2;
    localparam logic [FILT_W-1:0]  FILT_MAX   = 18'h3FFFF;
    localparam logic [SAT_W-1:0]   SAT_MAX    = 12'hFFF;

    // Queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [SMP_W-1:0]   sample;
        logic [COEFF_W-1:0] coeff;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel_out;
        logic [FILT_W-1:0] filtered;
        logic              peak_found;
        logic [AMP_W-1:0]  peak_amplitude;
    } out_t;

    // One classified, linearized sample waiting for the filter.
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            chan_ok;
        logic [X_W-1:0]  x0;
    } entry_t;

    // Handshake group from the queue head toward the back.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qhead_t;

    // Per-channel history word, newest sample in x1.
    typedef struct packed {
        logic [FILT_W-1:0] f1;
        logic [FILT_W-1:0] f0;
        logic [X_W-1:0]    x4;
        logic [X_W-1:0]    x3;
        logic [X_W-1:0]    x2;
        logic [X_W-1:0]    x1;
    } hist_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_FIN
    } back_state_t;

endpackage

// File: hw/rtl/linearize_fir_peak_finder.sv
// Linearizer, five-tap amplitude filter and peak finder with per-channel history.
// Input channel: in_valid / in_ready / in_data carry one word per sample: the
// channel number, the raw sample and its linearization word. Output channel:
// out_valid / out_ready / out_data carry one result word per input word, in
// the order the inputs were taken.
// The front multiplies as it accepts a word, shifts in the cycle after and drops
// it into a two-entry queue; the back reads the channel history, multiplies by
// the tap weights, then sums, clamps, finds the peak and writes the history back.
// The back sequencer takes a new word from the queue only after its read,
// multiply and write-back steps on the history memory finish for the last one.
// Reset clears the per-channel written flags, so every history reads as zero
// at once; there is no clearing pass and words are taken right after reset.
// When the receiver stalls, the finished result holds in the output register,
// the back waits with its next result, and the queue and front stage keep
// taking words until they are full, after which in_ready drops.
module linearize_fir_peak_finder #(
    parameter int CHANNELS = lfpf_pkg::CHANNELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lfpf_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lfpf_pkg::out_t  out_data
);

    logic              push;
    lfpf_pkg::entry_t  push_entry;
    logic              q_full;
    logic              pop;
    lfpf_pkg::qhead_t  head;

    // Front: accepts words, classifies the channel and linearizes the sample.
    lfpf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Short queue that lets the front keep running while the back is busy.
    lfpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    // Back: filter, clamp, peak search and history update, one word at a time.
    lfpf_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hw/rtl/lfpf_ram.sv
module lfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lfpf_queue.sv
module lfpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lfpf_pkg::entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output lfpf_pkg::qhead_t    head
);

    lfpf_pkg::entry_t               slot_reg [lfpf_pkg::QDEPTH];
    logic [lfpf_pkg::QAW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lfpf_pkg::QAW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lfpf_pkg::QAW:0]         count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full       = (count_reg == (lfpf_pkg::QAW + 1)'(lfpf_pkg::QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

endmodule

// File: hw/rtl/lfpf_front.sv
module lfpf_front #(
    parameter int CHANNELS = lfpf_pkg::CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lfpf_pkg::in_t     in_data,
    output logic              push,
    output lfpf_pkg::entry_t  push_entry,
    input  logic              q_full
);

    // Stage register holds the linearization product before the shift.
    logic                              stg_valid_reg, stg_valid_next;
    logic [lfpf_pkg::CH_W-1:0]         stg_ch_reg;
    logic                              stg_ok_reg;
    logic [lfpf_pkg::LPROD_W-1:0]      stg_prod_reg;
    logic [lfpf_pkg::SHAMT_W-1:0]      stg_shamt_reg;

    logic                              accept;
    logic [lfpf_pkg::ADC_W-1:0]        adc, ped, diff;
    logic [lfpf_pkg::MULT_W-1:0]       mult;
    logic [lfpf_pkg::SHF_W-1:0]        shf;
    logic                              zero_out;
    logic [lfpf_pkg::LPROD_W-1:0]      prod;
    logic                              chan_ok;
    logic [lfpf_pkg::LPROD_W-1:0]      shifted;

    assign adc  = in_data.sample[lfpf_pkg::ADC_W-1:0];
    assign ped  = in_data.coeff[11:0];
    assign shf  = in_data.coeff[15:12];
    assign mult = in_data.coeff[23:16];

    // A zero multiplier or a pedestal above the sample linearizes to zero.
    assign zero_out = (mult == '0) || (adc < ped);
    assign diff     = adc - ped;
    assign prod     = zero_out ? '0 : (lfpf_pkg::LPROD_W'(diff) * lfpf_pkg::LPROD_W'(mult));
    assign chan_ok  = (32'(in_data.channel) < 32'(CHANNELS));

    assign push     = stg_valid_reg && !q_full;
    assign in_ready = !stg_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_ch_reg    <= in_data.channel;
            stg_ok_reg    <= chan_ok;
            stg_prod_reg  <= prod;
            stg_shamt_reg <= lfpf_pkg::SHAMT_W'(shf) + lfpf_pkg::SHIFT_BIAS;
        end
    end

    assign shifted            = stg_prod_reg >> stg_shamt_reg;
    assign push_entry.channel = stg_ch_reg;
    assign push_entry.chan_ok = stg_ok_reg;
    assign push_entry.x0      = shifted[lfpf_pkg::X_W-1:0];

endmodule

// File: hw/rtl/lfpf_back.sv
module lfpf_back #(
    parameter int CHANNELS = lfpf_pkg::CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lfpf_pkg::qhead_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lfpf_pkg::out_t    out_data
);

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_W = $bits(lfpf_pkg::hist_t);

    lfpf_pkg::back_state_t state_reg, state_next;

    lfpf_pkg::entry_t                      item_reg;
    logic                                  hvld_reg;
    logic [CHANNELS-1:0]                   written_reg, written_next;
    logic signed [lfpf_pkg::TPROD_W-1:0]   tprod_reg [lfpf_pkg::NTAPS];
    logic [lfpf_pkg::FILT_W-1:0]           f0_reg, f1_reg;
    logic [HIST_W-1:0]                     nhist_reg;
    logic                                  out_valid_reg, out_valid_next;
    lfpf_pkg::out_t                        out_reg;

    // Sequencer outputs.
    logic                                  rd_en, ld_mul, finish;

    logic [AW-1:0]                         head_addr, item_addr;
    logic                                  head_vld;
    logic [HIST_W-1:0]                     rdata;
    lfpf_pkg::hist_t                       hist;
    logic [lfpf_pkg::X_W-1:0]              xs [lfpf_pkg::NTAPS];
    logic signed [lfpf_pkg::TERM_W-1:0]    term;
    logic signed [lfpf_pkg::ACC_W-1:0]     acc;
    logic [lfpf_pkg::FILT_W-1:0]           filt;
    logic                                  peak;
    logic [lfpf_pkg::SAT_W-1:0]            sat;
    lfpf_pkg::hist_t                       whist;
    logic                                  slot_free;

    assign head_addr = AW'(head.entry.channel);
    assign item_addr = AW'(item_reg.channel);
    assign head_vld  = head.entry.chan_ok ? written_reg[head_addr] : 1'b0;
    assign slot_free = !out_valid_reg || out_ready;

    lfpf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (finish && item_reg.chan_ok),
        .waddr (item_addr),
        .wdata (whist),
        .re    (rd_en),
        .raddr (head_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfpf_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = lfpf_pkg::BK_MUL;
                end
            end
            lfpf_pkg::BK_MUL:
            begin
                state_next = lfpf_pkg::BK_FIN;
            end
            lfpf_pkg::BK_FIN:
            begin
                if (slot_free)
                begin
                    state_next = lfpf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lfpf_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop    = 1'b0;
        rd_en  = 1'b0;
        ld_mul = 1'b0;
        finish = 1'b0;
        case (state_reg)
            lfpf_pkg::BK_IDLE:
            begin
                pop   = head.valid;
                rd_en = head.valid;
            end
            lfpf_pkg::BK_MUL:
            begin
                ld_mul = 1'b1;
            end
            lfpf_pkg::BK_FIN:
            begin
                finish = slot_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // History reads as zero for a channel never written or out of range.
    assign hist  = hvld_reg ? lfpf_pkg::hist_t'(rdata) : '0;
    assign xs[0] = item_reg.x0;
    assign xs[1] = hist.x1;
    assign xs[2] = hist.x2;
    assign xs[3] = hist.x3;
    assign xs[4] = hist.x4;

    // Each product is floored by an arithmetic shift, then summed at full width.
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < lfpf_pkg::NTAPS; i++)
        begin
            term = tprod_reg[i][lfpf_pkg::TPROD_W-1:lfpf_pkg::FRAC_W];
            acc  = acc + {{(lfpf_pkg::ACC_W - lfpf_pkg::TERM_W){term[lfpf_pkg::TERM_W-1]}},
                          term};
        end
    end

    always_comb
    begin
        if (acc[lfpf_pkg::ACC_W-1])
        begin
            filt = '0;
        end
        else if (acc > lfpf_pkg::ACC_W'(lfpf_pkg::FILT_MAX))
        begin
            filt = lfpf_pkg::FILT_MAX;
        end
        else
        begin
            filt = acc[lfpf_pkg::FILT_W-1:0];
        end
    end

    assign peak = (f0_reg > filt) && (f0_reg > f1_reg);
    assign sat  = (f0_reg > lfpf_pkg::FILT_W'(lfpf_pkg::SAT_MAX)) ?
                  lfpf_pkg::SAT_MAX : f0_reg[lfpf_pkg::SAT_W-1:0];

    always_comb
    begin
        whist    = lfpf_pkg::hist_t'(nhist_reg);
        whist.f1 = f0_reg;
        whist.f0 = filt;
    end

    always_comb
    begin
        written_next = written_reg;
        if (finish && item_reg.chan_ok)
        begin
            written_next[item_addr] = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfpf_pkg::BK_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.entry;
            hvld_reg <= head_vld;
        end
        if (ld_mul)
        begin
            for (int i = 0; i < lfpf_pkg::NTAPS; i++)
            begin
                tprod_reg[i] <= $signed({1'b0, xs[i]}) * lfpf_pkg::TAP_WGT[i];
            end
            f0_reg    <= hist.f0;
            f1_reg    <= hist.f1;
            nhist_reg <= {hist.f1, hist.f0, hist.x3, hist.x2, hist.x1, item_reg.x0};
        end
        if (finish)
        begin
            out_reg.channel_out    <= item_reg.channel;
            out_reg.filtered       <= filt;
            out_reg.peak_found     <= peak;
            out_reg.peak_amplitude <= peak ? sat[lfpf_pkg::SAT_W-1:2] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: verif/tb_linearize_fir_peak_finder.sv
`timescale 1ns / 1ps

// Self-checking bench for the linearizer, five-tap filter and peak finder.
// Every input word accepted by the block is run through a behavioral copy of
// the datapath kept in the scoreboard below. That copy tracks the per-channel
// sample and filter history on its own, so every result word that leaves the
// block can be compared field by field with the oldest prediction still waiting.
module tb_linearize_fir_peak_finder;

    localparam int CHANNELS    = lfpf_pkg::CHANNELS_DEF;
    localparam int TAPS_KEPT   = 4;
    localparam int N_RANDOM    = 1730;
    // The last stretch of the random words runs with no idling on either side.
    localparam int CALM_FROM   = 1480;
    // The receiver stops this long at a time, to fill the block and back it up.
    localparam int HOLD_CYCLES = 60;
    // Cycles with no accepted word on either side before the run is abandoned.
    localparam int STALL_LIMIT = 1000;
    // Cycles to wait after the last expected result, for any stray word.
    localparam int DRAIN       = 24;

    localparam int FIR_WEIGHT [5] = '{24, 31, 16, -35, -36};

    // Behavioral copy of the datapath, with its own history and a queue of
    // the result words it expects, oldest first.
    class fir_peak_scoreboard;
        bit [lfpf_pkg::X_W-1:0]    sample_taps [CHANNELS][TAPS_KEPT];
        bit [lfpf_pkg::FILT_W-1:0] past_filtered [CHANNELS][2];
        lfpf_pkg::out_t            expected_results [$];
        int                        mismatches = 0;

        function int pending();
            return expected_results.size();
        endfunction

        // ADC value minus pedestal, scaled by the multiplier and shifted down.
        // A zero multiplier or a pedestal above the ADC value gives zero.
        function bit [lfpf_pkg::X_W-1:0] linearize(bit [lfpf_pkg::SMP_W-1:0] smp,
                                                   bit [lfpf_pkg::COEFF_W-1:0] lin_word);
            bit [lfpf_pkg::ADC_W-1:0]   adc;
            bit [lfpf_pkg::ADC_W-1:0]   pedestal;
            bit [lfpf_pkg::SHF_W-1:0]   shift;
            bit [lfpf_pkg::MULT_W-1:0]  gain_mult;
            bit [lfpf_pkg::LPROD_W-1:0] product;
            adc       = smp[lfpf_pkg::ADC_W-1:0];
            pedestal  = lin_word[11:0];
            shift     = lin_word[15:12];
            gain_mult = lin_word[23:16];
            if (gain_mult == 0 || adc < pedestal)
                return '0;
            product = (adc - pedestal) * gain_mult;
            return lfpf_pkg::X_W'(product >> (shift + 2));
        endfunction

        function void note_input(lfpf_pkg::in_t w);
            bit [lfpf_pkg::X_W-1:0]    taps [5];
            bit [lfpf_pkg::FILT_W-1:0] newer;
            bit [lfpf_pkg::FILT_W-1:0] older;
            bit [lfpf_pkg::FILT_W-1:0] filt;
            bit                        in_range;
            longint                    acc;
            lfpf_pkg::out_t            result;
            in_range = w.channel < CHANNELS;
            taps[0] = linearize(w.sample, w.coeff);
            newer = '0;
            older = '0;
            for (int j = 0; j < TAPS_KEPT; j++)
                taps[j + 1] = '0;
            // A channel outside the table sees an all-zero history.
            if (in_range)
            begin
                for (int j = 0; j < TAPS_KEPT; j++)
                    taps[j + 1] = sample_taps[w.channel][j];
                newer = past_filtered[w.channel][0];
                older = past_filtered[w.channel][1];
            end
            // Each tap product is divided by 64 and floored before the sum.
            acc = 0;
            for (int j = 0; j < 5; j++)
                acc += (longint'(taps[j]) * FIR_WEIGHT[j]) >>> lfpf_pkg::FRAC_W;
            if (acc < 0)
                acc = 0;
            if (acc > longint'(lfpf_pkg::FILT_MAX))
                acc = longint'(lfpf_pkg::FILT_MAX);
            filt = lfpf_pkg::FILT_W'(acc);

            result.channel_out    = w.channel;
            result.filtered       = filt;
            result.peak_found     = newer > filt && newer > older;
            result.peak_amplitude = '0;
            if (result.peak_found)
                result.peak_amplitude = lfpf_pkg::AMP_W'(
                    ((newer > lfpf_pkg::SAT_MAX) ? lfpf_pkg::SAT_MAX : newer) >> 2);
            expected_results.push_back(result);

            if (in_range)
            begin
                for (int j = 0; j < TAPS_KEPT; j++)
                    sample_taps[w.channel][j] = taps[j];
                past_filtered[w.channel][1] = newer;
                past_filtered[w.channel][0] = filt;
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(lfpf_pkg::out_t got);
            lfpf_pkg::out_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word, channel", got.channel_out, -1);
                return;
            end
            want = expected_results.pop_front();
            if (got.channel_out !== want.channel_out)
                report_mismatch("channel_out", got.channel_out, want.channel_out);
            if (got.filtered !== want.filtered)
                report_mismatch("filtered", got.filtered, want.filtered);
            if (got.peak_found !== want.peak_found)
                report_mismatch("peak_found", got.peak_found, want.peak_found);
            if (got.peak_amplitude !== want.peak_amplitude)
                report_mismatch("peak_amplitude", got.peak_amplitude, want.peak_amplitude);
        endtask
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    lfpf_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    lfpf_pkg::out_t out_data;

    fir_peak_scoreboard board;
    bit calm;
    bit holding;
    int words_sent;
    int results_seen;
    int quiet_cycles;

    linearize_fir_peak_finder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Offers one word from a falling edge and keeps it steady until the block
    // takes it. Returns at the falling edge right after the acceptance, so the
    // next call can keep valid high without a gap.
    task automatic send_word(input lfpf_pkg::in_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(w);
        words_sent++;
        @(negedge clk);
    endtask

    // Sender gaps come in bursts. Every third block of words goes through
    // with none, and there are none while the receiver holds off on purpose.
    task automatic maybe_idle();
        if (!calm && !holding && ((words_sent / 150) % 3) != 0 && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    // Most random words look like real channel data: a channel in the table,
    // a small pedestal and a non-zero multiplier, so the histories fill with
    // live values and peaks come up often. The rest is raw noise over every
    // bit of every field, plus channels outside the table and zero multipliers.
    function automatic lfpf_pkg::in_t make_word();
        lfpf_pkg::in_t w;
        int            pick;
        pick = $urandom_range(0, 99);
        w.channel = lfpf_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
        w.sample  = {2'($urandom), ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 1023))
                                                               : 12'($urandom)};
        w.coeff   = {8'($urandom_range(1, 255)), 4'($urandom), 12'($urandom_range(0, 255))};
        if (pick >= 70 && pick < 90)
        begin
            w.channel = lfpf_pkg::CH_W'($urandom);
            w.sample  = lfpf_pkg::SMP_W'($urandom);
            w.coeff   = lfpf_pkg::COEFF_W'($urandom);
        end
        else if (pick >= 90 && pick < 95)
            w.channel = lfpf_pkg::CH_W'($urandom_range(CHANNELS, 7));
        else if (pick >= 95)
            w.coeff[23:16] = '0;
        return w;
    endfunction

    // Results are taken at the rising edge; the block's own registers change
    // only after this has read them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_result(out_data);
            results_seen++;
        end
    end

    // Watchdog: a long run of cycles with nothing taken on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("linearize_fir_peak_finder verification failed");
                $finish;
            end
        end
    end

    // Receiver: stalls in random bursts, has stretches with none, and twice
    // in the run holds off long enough for the block to fill and drop in_ready.
    initial
    begin
        int next_hold;
        next_hold = 300;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && results_seen >= next_hold)
            begin
                next_hold += 700;
                holding = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holding = 1'b0;
            end
            else if (!calm && ((results_seen / 80) % 3) != 1 && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        // Extremes of every field first, then the special cases: a pedestal
        // above the sample, a zero multiplier with the rest of the word set,
        // channels outside the table, a burst that drives the filter into
        // both clamps with a saturated peak, and a small pulse with a peak.
        lfpf_pkg::in_t directed_words [21];
        directed_words = '{
            {3'd0, 14'h0000, 24'h000000},
            {3'd0, 14'h3FFF, 24'hFF0000},
            {3'd0, 14'h0FFF, 24'hFFFFFF},
            {3'd0, 14'h0100, 24'h0A0200},
            {3'd0, 14'h3FFF, 24'h00FFFF},
            {3'd5, 14'h3FFF, 24'hFF0000},
            {3'd6, 14'h2ABC, 24'hFF0000},
            {3'd7, 14'h3FFF, 24'hFF0000},
            {3'd2, 14'h3FFF, 24'hFF0000},
            {3'd2, 14'h3FFF, 24'hFF0000},
            {3'd2, 14'h3FFF, 24'hFF0000},
            {3'd2, 14'h0000, 24'h000000},
            {3'd2, 14'h0000, 24'h000000},
            {3'd2, 14'h0000, 24'h000000},
            {3'd1, 14'h0400, 24'h408010},
            {3'd1, 14'h0800, 24'h408010},
            {3'd1, 14'h0C00, 24'h408010},
            {3'd1, 14'h0800, 24'h408010},
            {3'd1, 14'h0400, 24'h408010},
            {3'd4, 14'h2ABC, 24'h7F3123},
            {3'd3, 14'h1543, 24'h80C800}
        };

        board        = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        calm         = 1'b0;
        holding      = 1'b0;
        words_sent   = 0;
        results_seen = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
        begin
            maybe_idle();
            send_word(directed_words[i]);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == CALM_FROM)
                calm = 1'b1;
            maybe_idle();
            send_word(make_word());
        end
        in_valid <= 1'b0;

        // The watchdog bounds this wait if results stop coming.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("linearize_fir_peak_finder verification clean");
        else
            $display("linearize_fir_peak_finder verification failed");
        $finish;
    end

endmodule
